### hdl/dbtg_pkg.sv
`default_nettype none

package dbtg_pkg;

    // Sizes
    localparam int TABLE_DEPTH = 256;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int PHASE_W     = 32;
    localparam int IDX_PROD_W  = PHASE_W + IDX_W;
    localparam int SINE_W      = 28;
    localparam int AMP_W       = 18;
    localparam int STEP_W      = 16;
    localparam int COUNT_W     = 16;
    localparam int CODE_W      = 12;
    localparam int DAC_W       = 16;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 3;

    // Product of amplitude and sine, scaled down by 2^30 (two Q15 shifts)
    localparam int MUL_W    = AMP_W + SINE_W;
    localparam int MUL_SHR  = 30;
    localparam int SCALED_W = MUL_W - MUL_SHR;
    localparam int OFFS_W   = SCALED_W + 1;

    localparam logic signed [OFFS_W-1:0] CODE_MID = OFFS_W'(2048);
    localparam logic signed [OFFS_W-1:0] CODE_MAX = OFFS_W'(4095);

    localparam logic [DAC_W-1:0] CTRL_CHAN_A = 16'h3000;
    localparam logic [DAC_W-1:0] CTRL_CHAN_B = 16'hB000;

    localparam logic signed [AMP_W-1:0] AMP_MAX = {1'b0, {(AMP_W-1){1'b1}}};
    localparam logic signed [AMP_W-1:0] AMP_MIN = {1'b1, {(AMP_W-1){1'b0}}};

    // Reset values of the registers
    localparam logic [PHASE_W-1:0] RST_PHASE_INC   = 32'd85899345;
    localparam logic [STEP_W-1:0]  RST_ATTACK_STEP = 16'd163;
    localparam logic [STEP_W-1:0]  RST_DECAY_STEP  = 16'd163;
    localparam logic [COUNT_W-1:0] RST_ATTACK_LEN  = 16'd200;
    localparam logic [COUNT_W-1:0] RST_DECAY_START = 16'd10200;
    localparam logic [COUNT_W-1:0] RST_BEEP_LEN    = 16'd10400;
    localparam logic [COUNT_W-1:0] RST_SILENCE_LEN = 16'd40000;

    // Register map
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PHASE_INC   = 3'd0,
        CFG_ATTACK_STEP = 3'd1,
        CFG_DECAY_STEP  = 3'd2,
        CFG_ATTACK_LEN  = 3'd3,
        CFG_DECAY_START = 3'd4,
        CFG_BEEP_LEN    = 3'd5,
        CFG_SILENCE_LEN = 3'd6,
        CFG_CHAN_SEL    = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic [PHASE_W-1:0] phase_increment;
        logic [STEP_W-1:0]  attack_step;
        logic [STEP_W-1:0]  decay_step;
        logic [COUNT_W-1:0] attack_length;
        logic [COUNT_W-1:0] decay_start;
        logic [COUNT_W-1:0] beep_length;
        logic [COUNT_W-1:0] silence_length;
        logic               channel_select;
    } cfg_t;

    // One tone sample on its way from the envelope to the sample path
    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [AMP_W-1:0] amp;
        logic             chan;
    } tone_req_t;

    // Clamp a one-bit-wider sum to the amplitude range
    function automatic logic [AMP_W-1:0] sat_amp(input logic signed [AMP_W:0] v);
        logic [AMP_W-1:0] r;
        if (v > $signed({AMP_MAX[AMP_W-1], AMP_MAX}))
            r = AMP_MAX;
        else if (v < $signed({AMP_MIN[AMP_W-1], AMP_MIN}))
            r = AMP_MIN;
        else
            r = v[AMP_W-1:0];
        return r;
    endfunction

    // Sine table, built at elaboration (Q30 Taylor series)
    localparam logic [63:0] PI_Q30      = 64'd3373259426;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] THETA_DEN   = 64'(1000 * TABLE_DEPTH);

    function automatic logic [63:0] q30_mul(input logic [63:0] x, input logic [63:0] y);
        logic [63:0] p;
        p = (x * y) >> 30;
        return p;
    endfunction

    function automatic logic [63:0] q30_sq(input logic [63:0] x, input logic [63:0] a);
        logic [63:0] p;
        p = q30_mul(q30_mul(x, a), a);
        return p;
    endfunction

    function automatic logic [SINE_W-1:0] sine_entry(input int unsigned i);
        logic [63:0] theta;
        logic [63:0] a;
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] negsum;
        logic [63:0] mag;
        logic        neg;
        theta = ((64'(i) * 64'd6283) << 30) / THETA_DEN;
        neg   = 1'b0;
        if (theta >= PI_Q30) begin
            neg = 1'b1;
            a   = theta - PI_Q30;
        end else begin
            a = theta;
        end
        if (a > HALF_PI_Q30)
            a = (a > PI_Q30) ? 64'd0 : PI_Q30 - a;
        pos    = a;
        negsum = 64'd0;
        term   = q30_sq(a, a) / 64'd6;     negsum = negsum + term;
        term   = q30_sq(term, a) / 64'd20;  pos    = pos + term;
        term   = q30_sq(term, a) / 64'd42;  negsum = negsum + term;
        term   = q30_sq(term, a) / 64'd72;  pos    = pos + term;
        term   = q30_sq(term, a) / 64'd110; negsum = negsum + term;
        term   = q30_sq(term, a) / 64'd156; pos    = pos + term;
        term   = q30_sq(term, a) / 64'd210; negsum = negsum + term;
        term   = q30_sq(term, a) / 64'd272; pos    = pos + term;
        term   = q30_sq(term, a) / 64'd342; negsum = negsum + term;
        term   = q30_sq(term, a) / 64'd420; pos    = pos + term;
        term   = q30_sq(term, a) / 64'd506; negsum = negsum + term;
        term   = q30_sq(term, a) / 64'd600; pos    = pos + term;
        mag = (pos > negsum) ? pos - negsum : 64'd0;
        mag = (mag * 64'd2047) >> 15;
        return neg ? SINE_W'(-mag) : SINE_W'(mag);
    endfunction

    typedef logic [SINE_W-1:0] sine_table_t [TABLE_DEPTH];

    function automatic sine_table_t build_sine_table();
        sine_table_t t;
        for (int i = 0; i < TABLE_DEPTH; i++)
            t[i] = sine_entry(i);
        return t;
    endfunction

    localparam sine_table_t SINE_TABLE = build_sine_table();

endpackage

`default_nettype wire

### hdl/dds_beep_tone_generator_unit.sv
`default_nettype none

// Channel   Signals                                   Role
// tick      tick_valid, tick_stall, sample_tick       sample tick requests in
// sample    sample_valid, sample_stall,               one sample per tone tick
//           dac_word, sample_code
// config    cfg_write, cfg_index, cfg_data            register writes
//
// One tick request is taken every cycle while tick_stall is low; a tone tick's
// sample passes the envelope register, sine table register and result register.
// Silent ticks and ticks with sample_tick low give no sample.
// Reset restores register defaults, zeroes phase, amplitude and tick count.
// A sample_stall holds the result; tick_stall rises only once all stages fill.

module dds_beep_tone_generator_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               tick_valid,
    output logic                               tick_stall,
    input  logic                               sample_tick,
    output logic                               sample_valid,
    input  logic                               sample_stall,
    output logic [dbtg_pkg::DAC_W-1:0]         dac_word,
    output logic [dbtg_pkg::CODE_W-1:0]        sample_code,
    input  logic                               cfg_write,
    input  logic [dbtg_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [dbtg_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import dbtg_pkg::*;

    cfg_t      cfg;
    tone_req_t req;
    logic      req_valid;
    logic      req_ready;
    logic      busy;
    logic      tick_take;

    assign tick_stall = busy;
    assign tick_take  = tick_valid && !busy && sample_tick;

    dbtg_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    dbtg_envelope u_env (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .tick_take (tick_take),
        .busy      (busy),
        .req_valid (req_valid),
        .req       (req),
        .req_ready (req_ready)
    );

    dbtg_sample_path u_path (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req          (req),
        .req_ready    (req_ready),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .dac_word     (dac_word),
        .sample_code  (sample_code)
    );

endmodule

`default_nettype wire

### hdl/dbtg_cfg_regs.sv
`default_nettype none

module dbtg_cfg_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [dbtg_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [dbtg_pkg::CFG_DATA_W-1:0]    cfg_data,
    output dbtg_pkg::cfg_t                     cfg
);
    import dbtg_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_PHASE_INC:   cfg_next.phase_increment = cfg_data[PHASE_W-1:0];
                CFG_ATTACK_STEP: cfg_next.attack_step     = cfg_data[STEP_W-1:0];
                CFG_DECAY_STEP:  cfg_next.decay_step      = cfg_data[STEP_W-1:0];
                CFG_ATTACK_LEN:  cfg_next.attack_length   = cfg_data[COUNT_W-1:0];
                CFG_DECAY_START: cfg_next.decay_start     = cfg_data[COUNT_W-1:0];
                CFG_BEEP_LEN:    cfg_next.beep_length     = cfg_data[COUNT_W-1:0];
                CFG_SILENCE_LEN: cfg_next.silence_length  = cfg_data[COUNT_W-1:0];
                CFG_CHAN_SEL:    cfg_next.channel_select  = cfg_data[0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.phase_increment <= RST_PHASE_INC;
            cfg_reg.attack_step     <= RST_ATTACK_STEP;
            cfg_reg.decay_step      <= RST_DECAY_STEP;
            cfg_reg.attack_length   <= RST_ATTACK_LEN;
            cfg_reg.decay_start     <= RST_DECAY_START;
            cfg_reg.beep_length     <= RST_BEEP_LEN;
            cfg_reg.silence_length  <= RST_SILENCE_LEN;
            cfg_reg.channel_select  <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

### hdl/dbtg_envelope.sv
`default_nettype none

module dbtg_envelope (
    input  logic                  clk,
    input  logic                  rst_n,
    input  dbtg_pkg::cfg_t        cfg,
    input  logic                  tick_take,
    output logic                  busy,
    output logic                  req_valid,
    output dbtg_pkg::tone_req_t   req,
    input  logic                  req_ready
);
    import dbtg_pkg::*;

    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [AMP_W-1:0]   amp_reg, amp_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               silent_reg, silent_next;
    logic               req_valid_reg, req_valid_next;
    tone_req_t          req_reg, req_next;

    logic [PHASE_W-1:0]    phase_sum;
    logic [IDX_PROD_W-1:0] idx_prod;
    logic [COUNT_W-1:0]    count_inc;
    logic signed [AMP_W:0] amp_up;
    logic signed [AMP_W:0] amp_dn;

    // Phase step and table index, tick counter
    assign phase_sum = phase_reg + cfg.phase_increment;
    assign idx_prod  = IDX_PROD_W'(phase_sum) * IDX_PROD_W'(TABLE_DEPTH);
    assign count_inc = count_reg + COUNT_W'(1);
    assign amp_up    = $signed({amp_reg[AMP_W-1], amp_reg})
                       + $signed({{(AMP_W+1-STEP_W){1'b0}}, cfg.attack_step});
    assign amp_dn    = $signed({amp_reg[AMP_W-1], amp_reg})
                       - $signed({{(AMP_W+1-STEP_W){1'b0}}, cfg.decay_step});

    // Envelope state update, one step per accepted tick
    always_comb
    begin
        phase_next  = phase_reg;
        amp_next    = amp_reg;
        count_next  = count_reg;
        silent_next = silent_reg;
        req_next    = req_reg;
        if (tick_take)
        begin
            if (silent_reg)
            begin
                count_next = count_inc;
                if (count_inc == cfg.silence_length)
                begin
                    amp_next    = '0;
                    silent_next = 1'b0;
                    count_next  = '0;
                end
            end
            else
            begin
                phase_next   = phase_sum;
                req_next.idx  = idx_prod[PHASE_W +: IDX_W];
                req_next.amp  = amp_reg;
                req_next.chan = cfg.channel_select;
                if (count_reg < cfg.attack_length)
                    amp_next = sat_amp(amp_up);
                else if (count_reg > cfg.decay_start)
                    amp_next = sat_amp(amp_dn);
                count_next = count_inc;
                if (count_inc == cfg.beep_length)
                begin
                    silent_next = 1'b1;
                    count_next  = '0;
                end
            end
        end
    end

    // Request register toward the sample path
    assign req_valid_next = (req_valid_reg && !req_ready) || (tick_take && !silent_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= '0;
            amp_reg       <= '0;
            count_reg     <= '0;
            silent_reg    <= 1'b0;
            req_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            amp_reg       <= amp_next;
            count_reg     <= count_next;
            silent_reg    <= silent_next;
            req_valid_reg <= req_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
    end

    assign busy      = req_valid_reg && !req_ready;
    assign req_valid = req_valid_reg;
    assign req       = req_reg;

endmodule

`default_nettype wire

### hdl/dbtg_sample_path.sv
`default_nettype none

module dbtg_sample_path (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    input  dbtg_pkg::tone_req_t             req,
    output logic                            req_ready,
    output logic                            sample_valid,
    input  logic                            sample_stall,
    output logic [dbtg_pkg::DAC_W-1:0]      dac_word,
    output logic [dbtg_pkg::CODE_W-1:0]     sample_code
);
    import dbtg_pkg::*;

    logic              rom_valid_reg, rom_valid_next;
    logic [SINE_W-1:0] sine_reg;
    logic [AMP_W-1:0]  amp_reg;
    logic              chan_reg;
    logic              out_valid_reg, out_valid_next;
    logic [DAC_W-1:0]  dac_reg;
    logic [CODE_W-1:0] code_reg;

    logic                       out_ready;
    logic                       rom_ready;
    logic signed [MUL_W-1:0]    prod;
    logic signed [SCALED_W-1:0] scaled;
    logic signed [OFFS_W-1:0]   offs;
    logic [CODE_W-1:0]          code;
    logic [DAC_W-1:0]           ctrl;

    // Stage flow control
    assign out_ready      = !out_valid_reg || !sample_stall;
    assign rom_ready      = !rom_valid_reg || out_ready;
    assign rom_valid_next = rom_ready ? req_valid : rom_valid_reg;
    assign out_valid_next = out_ready ? rom_valid_reg : out_valid_reg;

    // Scale by amplitude, floor by 2^30, offset and clamp
    assign prod   = $signed(amp_reg) * $signed(sine_reg);
    assign scaled = prod[MUL_W-1:MUL_SHR];
    assign offs   = $signed({scaled[SCALED_W-1], scaled}) + CODE_MID;

    always_comb
    begin
        if (offs < 0)
            code = '0;
        else if (offs > CODE_MAX)
            code = CODE_MAX[CODE_W-1:0];
        else
            code = offs[CODE_W-1:0];
    end

    assign ctrl = chan_reg ? CTRL_CHAN_B : CTRL_CHAN_A;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rom_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rom_valid_reg <= rom_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Table read stage
    always_ff @(posedge clk)
    begin
        if (rom_ready && req_valid)
        begin
            sine_reg <= SINE_TABLE[req.idx];
            amp_reg  <= req.amp;
            chan_reg <= req.chan;
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (out_ready && rom_valid_reg)
        begin
            dac_reg  <= ctrl | {{(DAC_W-CODE_W){1'b0}}, code};
            code_reg <= code;
        end
    end

    assign req_ready    = rom_ready;
    assign sample_valid = out_valid_reg;
    assign dac_word     = dac_reg;
    assign sample_code  = code_reg;

endmodule

`default_nettype wire

### tb/dds_beep_tone_generator_unit_tb.sv
`timescale 1ns / 100ps

module dds_beep_tone_generator_unit_tb;

    import dbtg_pkg::*;

    localparam int SETTLE_CYCLES  = 8;
    localparam int DRAIN_CYCLES   = 12;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_TICKS   = 1350;

    localparam longint unsigned Q30_PI      = 64'd3373259426;
    localparam longint unsigned Q30_HALF_PI = 64'd1686629713;

    typedef struct packed {
        logic [DAC_W-1:0]  dac;
        logic [CODE_W-1:0] code;
    } sample_t;

    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_TICK,
        ROW_KNOWN
    } row_kind_e;

    typedef struct packed {
        row_kind_e         kind;
        cfg_index_t        idx;
        logic [31:0]       data;
        logic              tick;
        logic [DAC_W-1:0]  dac;
        logic [CODE_W-1:0] code;
    } stim_row_t;

    // DUT ports
    logic                   clk          = 1'b0;
    logic                   rst_n        = 1'b0;
    logic                   tick_valid   = 1'b0;
    logic                   tick_stall;
    logic                   sample_tick  = 1'b0;
    logic                   sample_valid;
    logic                   sample_stall = 1'b0;
    logic [DAC_W-1:0]       dac_word;
    logic [CODE_W-1:0]      sample_code;
    logic                   cfg_write    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index    = '0;
    logic [CFG_DATA_W-1:0]  cfg_data     = '0;

    // Tone model state
    cfg_t          tone_cfg;
    logic [31:0]   acc_phase;
    int            env_amp;
    logic [15:0]   beat_count;
    bit            in_silence;
    int            sine_lut [TABLE_DEPTH];

    sample_t       pending_samples [$];
    stim_row_t     dir_rows [$];
    sample_t       want;
    int            err_count   = 0;
    int            idle_cycles = 0;
    int            stall_left  = 0;
    bit            tx_calm     = 1'b0;
    bit            rx_calm     = 1'b0;

    dds_beep_tone_generator_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .tick_valid   (tick_valid),
        .tick_stall   (tick_stall),
        .sample_tick  (sample_tick),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .dac_word     (dac_word),
        .sample_code  (sample_code),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Q30 Taylor series sine, scaled to 2047 * 2^15
    function automatic int sine_q30(input int unsigned i);
        longint unsigned theta;
        longint unsigned a;
        longint unsigned term;
        longint unsigned pos;
        longint unsigned negs;
        longint unsigned mag;
        bit              neg;
        theta = ((64'(i) * 64'd6283) << 30) / 64'(1000 * TABLE_DEPTH);
        neg = 1'b0;
        a = theta;
        if (theta >= Q30_PI)
        begin
            neg = 1'b1;
            a = theta - Q30_PI;
        end
        if (a > Q30_HALF_PI)
            a = (a > Q30_PI) ? 64'd0 : Q30_PI - a;
        term = a;
        pos  = a;
        negs = 0;
        for (int k = 1; k <= 12; k++)
        begin
            term = (term * a) >> 30;
            term = (term * a) >> 30;
            term = term / (64'(2 * k) * 64'(2 * k + 1));
            if (k % 2 == 1)
                negs += term;
            else
                pos += term;
        end
        mag = (pos > negs) ? pos - negs : 64'd0;
        mag = (mag * 64'd2047) >> 15;
        return neg ? -int'(mag) : int'(mag);
    endfunction

    function automatic int clamp_int(input int v, input int lo, input int hi);
        if (v > hi)
            return hi;
        if (v < lo)
            return lo;
        return v;
    endfunction

    // One sample tick through the tone model; returns 1 when a sample is due
    function automatic bit tone_step(input logic tick, output logic [DAC_W-1:0] dac,
                                     output logic [CODE_W-1:0] code);
        int unsigned lut_idx;
        longint      prod;
        int          level;
        dac  = '0;
        code = '0;
        if (tick !== 1'b1)
            return 1'b0;
        if (in_silence)
        begin
            beat_count = beat_count + 16'd1;
            if (beat_count == tone_cfg.silence_length)
            begin
                env_amp    = 0;
                in_silence = 1'b0;
                beat_count = '0;
            end
            return 1'b0;
        end
        acc_phase = acc_phase + tone_cfg.phase_increment;
        lut_idx = int'((64'(acc_phase) * 64'(TABLE_DEPTH)) >> 32);
        prod  = longint'(env_amp) * longint'(sine_lut[lut_idx]);
        level = clamp_int(int'(prod >>> 30) + 2048, 0, 4095);
        code  = level[CODE_W-1:0];
        // envelope update uses the count before this tick
        if (beat_count < tone_cfg.attack_length)
            env_amp = clamp_int(env_amp + int'(tone_cfg.attack_step), -131072, 131071);
        else if (beat_count > tone_cfg.decay_start)
            env_amp = clamp_int(env_amp - int'(tone_cfg.decay_step), -131072, 131071);
        dac = (tone_cfg.channel_select ? CTRL_CHAN_B : CTRL_CHAN_A) | DAC_W'(code);
        beat_count = beat_count + 16'd1;
        if (beat_count == tone_cfg.beep_length)
        begin
            in_silence = 1'b1;
            beat_count = '0;
        end
        return 1'b1;
    endfunction

    function automatic logic [15:0] pick_step();
        case ($urandom_range(0, 5))
            0: return 16'd0;
            1: return 16'd32768;
            default: return 16'($urandom_range(0, 32768));
        endcase
    endfunction

    function automatic void cfg_row(input cfg_index_t idx, input logic [31:0] data);
        dir_rows.push_back('{kind: ROW_CFG, idx: idx, data: data, tick: 1'b0,
                             dac: '0, code: '0});
    endfunction

    function automatic void tick_row(input logic tick);
        dir_rows.push_back('{kind: ROW_TICK, idx: CFG_PHASE_INC, data: '0, tick: tick,
                             dac: '0, code: '0});
    endfunction

    function automatic void known_row(input logic [DAC_W-1:0] dac,
                                      input logic [CODE_W-1:0] code);
        dir_rows.push_back('{kind: ROW_KNOWN, idx: CFG_PHASE_INC, data: '0, tick: 1'b1,
                             dac: dac, code: code});
    endfunction

    // Drive one tick request; optional fixed expectation replaces the model's
    task automatic send_tick(input logic tick, input bit known,
                             input logic [DAC_W-1:0] kdac, input logic [CODE_W-1:0] kcode);
        sample_t s;
        bit      due;
        int      gap;
        int      roll;
        tick_valid  <= 1'b1;
        sample_tick <= tick;
        @(posedge clk);
        while (tick_stall)
            @(posedge clk);
        due = tone_step(tick, s.dac, s.code);
        if (known)
        begin
            s.dac  = kdac;
            s.code = kcode;
        end
        if (due)
            pending_samples.push_back(s);
        // sender gap: mostly none, some short, a few long
        gap = 0;
        if (!tx_calm)
        begin
            roll = $urandom_range(0, 99);
            if (roll >= 93)
                gap = $urandom_range(8, 40);
            else if (roll >= 65)
                gap = $urandom_range(1, 3);
        end
        if (gap != 0)
        begin
            tick_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Wait until the block is idle before touching registers
    task automatic settle();
        tick_valid <= 1'b0;
        while (pending_samples.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [31:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            CFG_PHASE_INC:   tone_cfg.phase_increment = data;
            CFG_ATTACK_STEP: tone_cfg.attack_step     = data[15:0];
            CFG_DECAY_STEP:  tone_cfg.decay_step      = data[15:0];
            CFG_ATTACK_LEN:  tone_cfg.attack_length   = data[15:0];
            CFG_DECAY_START: tone_cfg.decay_start     = data[15:0];
            CFG_BEEP_LEN:    tone_cfg.beep_length     = data[15:0];
            CFG_SILENCE_LEN: tone_cfg.silence_length  = data[15:0];
            CFG_CHAN_SEL:    tone_cfg.channel_select  = data[0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // Stimulus
    initial
    begin
        int        n;
        int        rand_ticks;
        int        r;
        stim_row_t row;

        for (int i = 0; i < TABLE_DEPTH; i++)
            sine_lut[i] = sine_q30(i);
        tone_cfg = '{phase_increment: RST_PHASE_INC, attack_step: RST_ATTACK_STEP,
                     decay_step: RST_DECAY_STEP, attack_length: RST_ATTACK_LEN,
                     decay_start: RST_DECAY_START, beep_length: RST_BEEP_LEN,
                     silence_length: RST_SILENCE_LEN, channel_select: 1'b0};
        acc_phase  = '0;
        env_amp    = 0;
        beat_count = '0;
        in_silence = 1'b0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset defaults: zero amplitude gives mid code on channel A
        known_row(16'h3800, 12'h800);
        tick_row(1'b1);
        // Force a short beep that brings the phase back to zero, then one
        // silent tick clears amplitude and count
        cfg_row(CFG_BEEP_LEN, 32'h0000_0003);
        cfg_row(CFG_PHASE_INC, 32'hF5C2_8F5E);   // minus two default increments
        cfg_row(CFG_SILENCE_LEN, 32'h0000_0001);
        tick_row(1'b1);
        tick_row(1'b1);
        // Quarter-turn phase steps, full-scale ramps; upper data bits are noise
        cfg_row(CFG_PHASE_INC, 32'h4000_0000);
        cfg_row(CFG_ATTACK_STEP, 32'h5A5A_8000);
        cfg_row(CFG_DECAY_STEP, 32'h0001_8000);
        cfg_row(CFG_ATTACK_LEN, 32'hABCD_0004);
        cfg_row(CFG_DECAY_START, 32'hFFFF_0007);
        cfg_row(CFG_BEEP_LEN, 32'h1234_0012);
        cfg_row(CFG_SILENCE_LEN, 32'h0000_0002);
        cfg_row(CFG_CHAN_SEL, 32'hFFFF_FFFF);
        known_row(16'hB800, 12'h800);
        tick_row(1'b1);
        tick_row(1'b0);                          // zero tick is ignored
        tick_row(1'b1);
        known_row(16'hB800, 12'h800);            // zero sine entry
        known_row(16'hBFFF, 12'hFFF);            // peak at max amplitude clips high
        tick_row(1'b1);
        known_row(16'hB000, 12'h000);            // trough at max amplitude clips low
        known_row(16'hB800, 12'h800);
        tick_row(1'b1);
        tick_row(1'b1);
        tick_row(1'b1);
        known_row(16'hB800, 12'h800);
        tick_row(1'b1);
        tick_row(1'b1);
        tick_row(1'b1);
        known_row(16'hB800, 12'h800);
        known_row(16'hB000, 12'h000);            // peak at min amplitude clips low
        tick_row(1'b1);
        tick_row(1'b1);                          // silence
        tick_row(1'b1);
        known_row(16'hB800, 12'h800);            // amplitude cleared after silence

        foreach (dir_rows[i])
        begin
            row = dir_rows[i];
            case (row.kind)
                ROW_CFG:
                begin
                    settle();
                    write_reg(row.idx, row.data);
                end
                ROW_TICK:  send_tick(row.tick, 1'b0, '0, '0);
                ROW_KNOWN: send_tick(1'b1, 1'b1, row.dac, row.code);
                default: ;
            endcase
        end

        // Random phases: new settings each phase, then a run of tick requests
        rand_ticks = 0;
        while (rand_ticks < RANDOM_TICKS)
        begin
            settle();
            case ($urandom_range(0, 7))
                0: write_reg(CFG_PHASE_INC, 32'h0000_0000);
                1: write_reg(CFG_PHASE_INC, 32'hFFFF_FFFF);
                2: write_reg(CFG_PHASE_INC, 32'h8000_0000);
                default: write_reg(CFG_PHASE_INC, $urandom);
            endcase
            write_reg(CFG_ATTACK_STEP, {16'($urandom), pick_step()});
            write_reg(CFG_DECAY_STEP, {16'($urandom), pick_step()});
            r = $urandom_range(0, 9);
            write_reg(CFG_ATTACK_LEN, {16'($urandom),
                      (r == 0) ? 16'd0 : (r == 1) ? 16'hFFFF : 16'($urandom_range(1, 30))});
            r = $urandom_range(0, 9);
            write_reg(CFG_DECAY_START, {16'($urandom),
                      (r == 0) ? 16'd0 : (r == 1) ? 16'hFFFF : 16'($urandom_range(0, 40))});
            r = $urandom_range(0, 19);
            write_reg(CFG_BEEP_LEN, {16'($urandom),
                      (r == 0) ? 16'd1 : (r == 1) ? 16'hFFFF : 16'($urandom_range(2, 40))});
            r = $urandom_range(0, 19);
            write_reg(CFG_SILENCE_LEN, {16'($urandom),
                      (r == 0) ? 16'd1 : (r == 1) ? 16'hFFFF : 16'($urandom_range(1, 12))});
            write_reg(CFG_CHAN_SEL, $urandom);
            tx_calm = ($urandom_range(0, 4) == 0);
            rx_calm = ($urandom_range(0, 4) == 0);
            n = $urandom_range(30, 80);
            repeat (n) send_tick(($urandom_range(0, 9) != 0), 1'b0, '0, '0);
            rand_ticks += n;
        end

        // Drain and report
        tick_valid <= 1'b0;
        while (pending_samples.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("dds_beep_tone_generator_unit_tb passed");
        else
            $display("dds_beep_tone_generator_unit_tb failed");
        $finish;
    end

    // Sample checker and receiver stall
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (sample_valid && !sample_stall)
            begin
                if (pending_samples.size() == 0)
                begin
                    $error("sample with none expected: dac_word %h sample_code %h",
                           dac_word, sample_code);
                    err_count++;
                end
                else
                begin
                    want = pending_samples.pop_front();
                    if (dac_word !== want.dac)
                    begin
                        $error("dac_word expected %h actual %h", want.dac, dac_word);
                        err_count++;
                    end
                    if (sample_code !== want.code)
                    begin
                        $error("sample_code expected %h actual %h", want.code, sample_code);
                        err_count++;
                    end
                end
            end
            // stall: mostly short bursts, a few long ones
            if (stall_left != 0)
            begin
                stall_left--;
                sample_stall <= 1'b1;
            end
            else if (!rx_calm && $urandom_range(0, 99) < 20)
            begin
                stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                                          : $urandom_range(0, 2);
                sample_stall <= 1'b1;
            end
            else
            begin
                sample_stall <= 1'b0;
            end
        end
    end

    // Watchdog: cycles with no request moved and no register written
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((tick_valid && !tick_stall) || (sample_valid && !sample_stall) || cfg_write)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("dds_beep_tone_generator_unit_tb failed");
                $finish;
            end
        end
    end

endmodule
